FILE: src/signed_integer_divider_defines.svh
// ----------------------------------------------------------------------------
// signed integer divider assertion macros
// shared assertion forms for the divider, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_DIVIDER_DEFINES_SVH
`define SIGNED_INTEGER_DIVIDER_DEFINES_SVH

// same-cycle implication
`define SID_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("signed_integer_divider: same-cycle check failed");

// next-cycle implication
`define SID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("signed_integer_divider: next-cycle check failed");

`endif

FILE: src/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// widths, status codes and stage types shared by the divider pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sid_pkg;

   // operand width
   localparam int DATA_WIDTH = 32;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // control that travels with each item
   typedef struct packed {
      logic       valid;
      logic       neg_q;
      logic       neg_r;
      logic [1:0] status;
   } ctrl_type;

   // division working set: partial remainder, dividend/quotient shift word, divisor
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] dvs;
   } data_type;

endpackage

FILE: src/signed_integer_divider.sv
// ----------------------------------------------------------------------------
// signed_integer_divider
// pipelined signed division, quotient truncated toward zero
// ----------------------------------------------------------------------------
// usage:
//   req channel takes an item of req_dividend and req_divisor when req_valid
//   is high and req_stall is low; rsp channel delivers rsp_quotient,
//   rsp_remainder and rsp_status when rsp_valid is high and rsp_stall is low.
//   the remainder carries the sign of the dividend. a zero divisor returns
//   status divide-by-zero with zero results; the most negative dividend over
//   minus one returns status overflow with the most negative quotient.
// stages: one sign stage, one restoring subtract stage per quotient bit,
//   one fix-up stage.
// throughput: one item per cycle while no result is held under rsp_stall; each bit stage has its own subtractor.
// stall: the whole pipeline freezes while a result waits under rsp_stall;
//   req_stall is raised in those cycles and nothing is lost or repeated.
// reset: clears all valid bits, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_integer_divider_defines.svh"

module signed_integer_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] req_dividend,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] req_divisor,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_quotient,
   output logic signed [sid_pkg::DATA_WIDTH-1:0] rsp_remainder,
   output logic [1:0]                            rsp_status
);

   localparam logic [sid_pkg::DATA_WIDTH-1:0] MIN_VALUE =
      {1'b1, {(sid_pkg::DATA_WIDTH-1){1'b0}}};

   logic advance;

   sid_pkg::ctrl_type ctrl_stage [sid_pkg::DATA_WIDTH+1];
   sid_pkg::data_type data_stage [sid_pkg::DATA_WIDTH+1];

   // pipeline moves unless a finished result is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // sign and special case stage
   sid_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .valid    (req_valid),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .ctrl_out (ctrl_stage[0]),
      .data_out (data_stage[0])
   );

   // one quotient bit per stage
   for (genvar i = 0; i < sid_pkg::DATA_WIDTH; i++) begin : g_step
      sid_step u_step (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .ctrl_in_port (ctrl_stage[i]),
         .data_in_port (data_stage[i]),
         .ctrl_out     (ctrl_stage[i+1]),
         .data_out     (data_stage[i+1])
      );
   end

   // sign fix-up and result register
   sid_fix u_fix (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .ctrl_in_port (ctrl_stage[sid_pkg::DATA_WIDTH]),
      .data_in_port (data_stage[sid_pkg::DATA_WIDTH]),
      .valid        (rsp_valid),
      .quotient     (rsp_quotient),
      .remainder    (rsp_remainder),
      .status       (rsp_status)
   );

   // checks
   `SID_ASSERT_NOW(a_div_zero_results, rsp_valid && rsp_status == sid_pkg::STATUS_DIV_ZERO, rsp_quotient == '0 && rsp_remainder == '0)
   `SID_ASSERT_NOW(a_overflow_results, rsp_valid && rsp_status == sid_pkg::STATUS_OVERFLOW, rsp_quotient == MIN_VALUE && rsp_remainder == '0)
   `SID_ASSERT_NEXT(a_held_result_kept, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))

endmodule

FILE: src/sid_prep.sv
// ----------------------------------------------------------------------------
// sid_prep
// input stage: operand magnitudes, sign flags and special case detection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sid_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  valid,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] dividend,
   input  logic signed [sid_pkg::DATA_WIDTH-1:0] divisor,
   output sid_pkg::ctrl_type                     ctrl_out,
   output sid_pkg::data_type                     data_out
);

   localparam logic [sid_pkg::DATA_WIDTH-1:0] MIN_VALUE =
      {1'b1, {(sid_pkg::DATA_WIDTH-1){1'b0}}};

   sid_pkg::ctrl_type ctrl_ff;
   sid_pkg::ctrl_type ctrl_in;
   sid_pkg::data_type data_ff;
   sid_pkg::data_type data_in;

   logic [sid_pkg::DATA_WIDTH-1:0] a_bits;
   logic [sid_pkg::DATA_WIDTH-1:0] b_bits;
   logic                           a_neg;
   logic                           b_neg;

   // magnitudes and status
   always_comb begin
      a_bits = dividend;
      b_bits = divisor;
      a_neg  = a_bits[sid_pkg::DATA_WIDTH-1];
      b_neg  = b_bits[sid_pkg::DATA_WIDTH-1];

      ctrl_in.valid = valid;
      ctrl_in.neg_q = a_neg ^ b_neg;
      ctrl_in.neg_r = a_neg;
      if (b_bits == '0) begin
         ctrl_in.status = sid_pkg::STATUS_DIV_ZERO;
      end else if (a_bits == MIN_VALUE && b_bits == '1) begin
         ctrl_in.status = sid_pkg::STATUS_OVERFLOW;
      end else begin
         ctrl_in.status = sid_pkg::STATUS_OK;
      end

      data_in.rem = '0;
      data_in.quo = a_neg ? (~a_bits + 1'b1) : a_bits;
      data_in.dvs = b_neg ? (~b_bits + 1'b1) : b_bits;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff.neg_q  <= ctrl_in.neg_q;
         ctrl_ff.neg_r  <= ctrl_in.neg_r;
         ctrl_ff.status <= ctrl_in.status;
         data_ff        <= data_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

FILE: src/sid_step.sv
// ----------------------------------------------------------------------------
// sid_step
// one restoring division stage: produces one quotient bit per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sid_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  sid_pkg::ctrl_type ctrl_in_port,
   input  sid_pkg::data_type data_in_port,
   output sid_pkg::ctrl_type ctrl_out,
   output sid_pkg::data_type data_out
);

   sid_pkg::ctrl_type ctrl_ff;
   sid_pkg::data_type data_ff;
   sid_pkg::data_type data_in;

   logic [sid_pkg::DATA_WIDTH:0]   shifted;
   logic [sid_pkg::DATA_WIDTH+1:0] diff;

   // shift in the next dividend bit, trial subtract, keep or restore
   always_comb begin
      shifted = {data_in_port.rem, data_in_port.quo[sid_pkg::DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {2'b00, data_in_port.dvs};
      data_in.dvs = data_in_port.dvs;
      if (diff[sid_pkg::DATA_WIDTH+1]) begin
         data_in.rem = shifted[sid_pkg::DATA_WIDTH-1:0];
         data_in.quo = {data_in_port.quo[sid_pkg::DATA_WIDTH-2:0], 1'b0};
      end else begin
         data_in.rem = diff[sid_pkg::DATA_WIDTH-1:0];
         data_in.quo = {data_in_port.quo[sid_pkg::DATA_WIDTH-2:0], 1'b1};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in_port.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff.neg_q  <= ctrl_in_port.neg_q;
         ctrl_ff.neg_r  <= ctrl_in_port.neg_r;
         ctrl_ff.status <= ctrl_in_port.status;
         data_ff        <= data_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

FILE: src/sid_fix.sv
// ----------------------------------------------------------------------------
// sid_fix
// output stage: sign fix-up, special case results and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sid_fix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  sid_pkg::ctrl_type                     ctrl_in_port,
   input  sid_pkg::data_type                     data_in_port,
   output logic                                  valid,
   output logic signed [sid_pkg::DATA_WIDTH-1:0] quotient,
   output logic signed [sid_pkg::DATA_WIDTH-1:0] remainder,
   output logic [1:0]                            status
);

   localparam logic [sid_pkg::DATA_WIDTH-1:0] MIN_VALUE =
      {1'b1, {(sid_pkg::DATA_WIDTH-1){1'b0}}};

   logic                           valid_ff;
   logic [sid_pkg::DATA_WIDTH-1:0] quotient_ff;
   logic [sid_pkg::DATA_WIDTH-1:0] quotient_in;
   logic [sid_pkg::DATA_WIDTH-1:0] remainder_ff;
   logic [sid_pkg::DATA_WIDTH-1:0] remainder_in;
   logic [1:0]                     status_ff;

   // apply signs, override special cases
   always_comb begin
      case (ctrl_in_port.status)
         sid_pkg::STATUS_DIV_ZERO: begin
            quotient_in  = '0;
            remainder_in = '0;
         end
         sid_pkg::STATUS_OVERFLOW: begin
            quotient_in  = MIN_VALUE;
            remainder_in = '0;
         end
         default: begin
            quotient_in  = ctrl_in_port.neg_q ? (~data_in_port.quo + 1'b1)
                                              : data_in_port.quo;
            remainder_in = ctrl_in_port.neg_r ? (~data_in_port.rem + 1'b1)
                                              : data_in_port.rem;
         end
      endcase
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctrl_in_port.valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (enable) begin
         quotient_ff  <= quotient_in;
         remainder_ff <= remainder_in;
         status_ff    <= ctrl_in_port.status;
      end
   end

   assign valid     = valid_ff;
   assign quotient  = quotient_ff;
   assign remainder = remainder_ff;
   assign status    = status_ff;

endmodule
